FILE: design/tts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the terminal text screen engine.
package tts_pkg;

   localparam int MAX_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF = 32;

   localparam int CFG_W = 6;
   localparam int CALC_W = 10;
   localparam logic [CFG_W-1:0] ROWS_RESET = 6'd30;
   localparam logic [CFG_W-1:0] COLS_RESET = 6'd30;
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   localparam logic [7:0] BLANK = 8'h20;

   localparam logic [3:0] KIND_PRINT   = 4'd0;
   localparam logic [3:0] KIND_CLEAR   = 4'd1;
   localparam logic [3:0] KIND_BACK    = 4'd2;
   localparam logic [3:0] KIND_DOWN    = 4'd3;
   localparam logic [3:0] KIND_FWD     = 4'd4;
   localparam logic [3:0] KIND_POS     = 4'd5;
   localparam logic [3:0] KIND_UP      = 4'd6;
   localparam logic [3:0] KIND_DELETE  = 4'd7;
   localparam logic [3:0] KIND_ERASE   = 4'd8;
   localparam logic [3:0] KIND_HOME    = 4'd9;
   localparam logic [3:0] KIND_COL     = 4'd10;
   localparam logic [3:0] KIND_SAVE    = 4'd11;
   localparam logic [3:0] KIND_RESTORE = 4'd12;
   localparam logic [3:0] KIND_ROW     = 4'd13;
   localparam logic [3:0] KIND_READ    = 4'd14;
   localparam logic [3:0] KIND_NOP     = 4'd15;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] char_code;
      logic [7:0] param_a;
      logic [7:0] param_b;
   } tts_req_type;

   typedef struct packed {
      logic [4:0] cursor_row;
      logic [4:0] cursor_col;
      logic [7:0] read_char;
   } tts_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } walk_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CLEAR,
      ST_EXEC,
      ST_READ,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_FILL
   } tts_state_type;

   function automatic logic [CALC_W-1:0] lim_val(input logic [CFG_W-1:0] cfg,
                                                 input logic [CALC_W-1:0] max_val);
      logic [CALC_W-1:0] wide;
      wide = CALC_W'(cfg);
      if (wide == '0) begin
         return CALC_W'(1);
      end else if (wide > max_val) begin
         return max_val;
      end
      return wide;
   endfunction

   function automatic logic [CALC_W-1:0] sat_val(input logic [CALC_W-1:0] v,
                                                 input logic [CALC_W-1:0] n);
      return (v < n) ? v : n - CALC_W'(1);
   endfunction

endpackage

FILE: design/tts_mem.sv
`timescale 1ns / 1ps
// Screen cell memory with one write port and one registered read port.
module tts_mem #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] cells_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         cells_ff[waddr] <= wdata;
      end
      rdata_ff <= cells_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/tts_walk.sv
`timescale 1ns / 1ps
// Shared index walker: one counter with an offset adder and a limit compare.
module tts_walk #(
   parameter int WW = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tts_pkg::walk_ctl_type ctl,
   input  logic [WW-1:0]         start_idx,
   input  logic [WW-1:0]         offset,
   input  logic [WW-1:0]         limit,
   output logic [WW-1:0]         idx,
   output logic [WW-1:0]         sum,
   output logic                  more
);

   logic [WW-1:0] idx_ff;
   logic [WW-1:0] idx_in;

   always_comb begin
      idx_in = idx_ff;
      if (ctl.load) begin
         idx_in = start_idx;
      end else if (ctl.step) begin
         idx_in = idx_ff + WW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign idx  = idx_ff;
   assign sum  = idx_ff + offset;
   assign more = (sum < limit);

endmodule

FILE: design/tts_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: cursor state, command decode and cell walks over the shared walker.
module tts_ctrl #(
   parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = tts_pkg::MAX_COLS_DEF,
   localparam int DEPTH = MAX_ROWS * MAX_COLS,
   localparam int AW = $clog2(DEPTH),
   localparam int WW = $clog2(DEPTH + 1),
   localparam int NRW = $clog2(MAX_ROWS + 1),
   localparam int NCW = $clog2(MAX_COLS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tts_pkg::tts_req_type  req_data,
   output logic                  rsp_valid,
   output tts_pkg::tts_rsp_type  rsp_data,
   input  logic [NRW-1:0]        nr,
   input  logic [NCW-1:0]        nc,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_waddr,
   output logic [7:0]            mem_wdata,
   output logic [AW-1:0]         mem_raddr,
   input  logic [7:0]            mem_rdata,
   output tts_pkg::walk_ctl_type walk_ctl,
   output logic [WW-1:0]         walk_start,
   output logic [WW-1:0]         walk_off,
   output logic [WW-1:0]         walk_lim,
   input  logic [WW-1:0]         walk_idx,
   input  logic [WW-1:0]         walk_sum,
   input  logic                  walk_more
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int CALC_W = tts_pkg::CALC_W;

   tts_pkg::tts_state_type state_ff, state_in;
   tts_pkg::tts_req_type   cmd_ff, cmd_in;
   tts_pkg::tts_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]          cur_row_ff, cur_row_in, sav_row_ff, sav_row_in;
   logic [CW-1:0]          cur_col_ff, cur_col_in, sav_col_ff, sav_col_in;
   logic [WW-1:0]          off_ff, off_in, end_ff, end_in;

   logic [CALC_W-1:0] row_w, col_w, nr_w, nc_w, pa_w, pb_w, span_w, cnt_w;
   logic [AW-1:0]     base, read_addr;
   logic [7:0]        rd;
   logic              finish;

   always_comb begin
      row_w  = CALC_W'(cur_row_ff);
      col_w  = CALC_W'(cur_col_ff);
      nr_w   = CALC_W'(nr);
      nc_w   = CALC_W'(nc);
      pa_w   = CALC_W'(cmd_ff.param_a);
      pb_w   = CALC_W'(cmd_ff.param_b);
      span_w = nc_w - col_w;
      cnt_w  = (pa_w > span_w) ? span_w : pa_w;
      base   = AW'(cur_row_ff) * AW'(MAX_COLS);
      read_addr = AW'(tts_pkg::sat_val(pb_w, nr_w)) * AW'(MAX_COLS)
                + AW'(tts_pkg::sat_val(pa_w, nc_w));
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      sav_row_in = sav_row_ff;
      sav_col_in = sav_col_ff;
      off_in     = off_ff;
      end_in     = end_ff;
      mem_we     = 1'b0;
      mem_waddr  = base + AW'(walk_idx);
      mem_wdata  = tts_pkg::BLANK;
      mem_raddr  = base + AW'(walk_sum);
      walk_ctl   = '0;
      walk_start = '0;
      walk_off   = '0;
      walk_lim   = WW'(DEPTH);
      finish     = 1'b0;
      rd         = '0;
      case (state_ff)
         tts_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in     = req_data;
               cur_row_in = RW'(tts_pkg::sat_val(row_w, nr_w));
               cur_col_in = CW'(tts_pkg::sat_val(col_w, nc_w));
               state_in   = tts_pkg::ST_EXEC;
            end
         end
         tts_pkg::ST_INIT, tts_pkg::ST_CLEAR: begin
            if (walk_more) begin
               mem_we        = 1'b1;
               mem_waddr     = AW'(walk_idx);
               walk_ctl.step = 1'b1;
            end else begin
               finish   = (state_ff == tts_pkg::ST_CLEAR);
               state_in = tts_pkg::ST_IDLE;
            end
         end
         tts_pkg::ST_EXEC: begin
            finish   = 1'b1;
            state_in = tts_pkg::ST_IDLE;
            case (cmd_ff.kind)
               tts_pkg::KIND_PRINT: begin
                  mem_we     = 1'b1;
                  mem_waddr  = base + AW'(cur_col_ff);
                  mem_wdata  = cmd_ff.char_code;
                  cur_col_in = CW'(tts_pkg::sat_val(col_w + CALC_W'(1), nc_w));
               end
               tts_pkg::KIND_CLEAR: begin
                  finish        = 1'b0;
                  walk_ctl.load = 1'b1;
                  cur_row_in    = '0;
                  cur_col_in    = '0;
                  state_in      = tts_pkg::ST_CLEAR;
               end
               tts_pkg::KIND_BACK: begin
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - CW'(1);
                  end
               end
               tts_pkg::KIND_DOWN: begin
                  cur_row_in = RW'(tts_pkg::sat_val(row_w + CALC_W'(1), nr_w));
                  cur_col_in = '0;
               end
               tts_pkg::KIND_FWD: begin
                  cur_col_in = CW'(tts_pkg::sat_val(col_w + CALC_W'(1), nc_w));
               end
               tts_pkg::KIND_POS: begin
                  cur_col_in = CW'(tts_pkg::sat_val(pa_w, nc_w));
                  cur_row_in = RW'(tts_pkg::sat_val(pb_w, nr_w));
               end
               tts_pkg::KIND_UP: begin
                  cur_row_in = (pa_w >= row_w) ? '0 : RW'(row_w - pa_w);
               end
               tts_pkg::KIND_DELETE: begin
                  finish        = 1'b0;
                  walk_ctl.load = 1'b1;
                  walk_start    = WW'(cur_col_ff);
                  off_in        = WW'(cnt_w);
                  end_in        = WW'(nc);
                  state_in      = tts_pkg::ST_DEL_RD;
               end
               tts_pkg::KIND_ERASE: begin
                  finish        = 1'b0;
                  walk_ctl.load = 1'b1;
                  walk_start    = WW'(cur_col_ff);
                  end_in        = WW'(col_w + cnt_w);
                  state_in      = tts_pkg::ST_FILL;
               end
               tts_pkg::KIND_HOME: begin
                  cur_row_in = '0;
                  cur_col_in = '0;
               end
               tts_pkg::KIND_COL: begin
                  cur_col_in = CW'(tts_pkg::sat_val(pa_w, nc_w));
               end
               tts_pkg::KIND_SAVE: begin
                  sav_row_in = cur_row_ff;
                  sav_col_in = cur_col_ff;
               end
               tts_pkg::KIND_RESTORE: begin
                  cur_row_in = RW'(tts_pkg::sat_val(CALC_W'(sav_row_ff), nr_w));
                  cur_col_in = CW'(tts_pkg::sat_val(CALC_W'(sav_col_ff), nc_w));
               end
               tts_pkg::KIND_ROW: begin
                  cur_row_in = RW'(tts_pkg::sat_val(pa_w, nr_w));
               end
               tts_pkg::KIND_READ: begin
                  finish    = 1'b0;
                  mem_raddr = read_addr;
                  state_in  = tts_pkg::ST_READ;
               end
               default: begin
               end
            endcase
         end
         tts_pkg::ST_READ: begin
            finish   = 1'b1;
            rd       = mem_rdata;
            state_in = tts_pkg::ST_IDLE;
         end
         tts_pkg::ST_DEL_RD: begin
            walk_off = off_ff;
            walk_lim = WW'(nc);
            if (walk_more) begin
               state_in = tts_pkg::ST_DEL_WR;
            end else begin
               state_in = tts_pkg::ST_FILL;
            end
         end
         tts_pkg::ST_DEL_WR: begin
            mem_we        = 1'b1;
            mem_wdata     = mem_rdata;
            walk_ctl.step = 1'b1;
            state_in      = tts_pkg::ST_DEL_RD;
         end
         tts_pkg::ST_FILL: begin
            walk_lim = end_ff;
            if (walk_more) begin
               mem_we        = 1'b1;
               walk_ctl.step = 1'b1;
            end else begin
               finish   = 1'b1;
               state_in = tts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tts_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in           = finish;
      rsp_data_in.cursor_row = 5'(cur_row_in);
      rsp_data_in.cursor_col = 5'(cur_col_in);
      rsp_data_in.read_char  = rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::ST_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         sav_row_ff   <= '0;
         sav_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         sav_row_ff   <= sav_row_in;
         sav_col_ff   <= sav_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      off_ff      <= off_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != tts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/terminal_text_screen_engine.sv
`timescale 1ns / 1ps
// Top level: configuration registers and the screen engine datapath.
// Cursor, print, save, restore, nop: result registered from the execute state, one at a time.
// Read: result after an extra read state, set by the registered memory read port.
// Erase blanks n cells; delete shifts kept cells left, then blanks the row tail.
// Clear: every cell of the store, one per cycle.
// Reset is synchronous; afterward busy stays high while the store is blanked.
module terminal_text_screen_engine #(
   parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = tts_pkg::MAX_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tts_pkg::tts_req_type req_data,
   output logic                 rsp_valid,
   output tts_pkg::tts_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam int WW = $clog2(DEPTH + 1);
   localparam int NRW = $clog2(MAX_ROWS + 1);
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int CFG_W = tts_pkg::CFG_W;
   localparam int CALC_W = tts_pkg::CALC_W;

   logic [CFG_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic             csr_wr;
   logic [NRW-1:0]   nr;
   logic [NCW-1:0]   nc;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [7:0]            mem_wdata, mem_rdata;
   tts_pkg::walk_ctl_type walk_ctl;
   logic [WW-1:0]         walk_start, walk_off, walk_lim, walk_idx, walk_sum;
   logic                  walk_more;

   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr) begin
         case (paddr[2])
            tts_pkg::REG_ROWS: rows_in = pwdata[CFG_W-1:0];
            tts_pkg::REG_COLS: cols_in = pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= tts_pkg::ROWS_RESET;
         cols_ff <= tts_pkg::COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign prdata = (paddr[2] == tts_pkg::REG_COLS) ? 32'(cols_ff) : 32'(rows_ff);

   assign nr = NRW'(tts_pkg::lim_val(rows_ff, CALC_W'(MAX_ROWS)));
   assign nc = NCW'(tts_pkg::lim_val(cols_ff, CALC_W'(MAX_COLS)));

   tts_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   tts_walk #(
      .WW(WW)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .ctl      (walk_ctl),
      .start_idx(walk_start),
      .offset   (walk_off),
      .limit    (walk_lim),
      .idx      (walk_idx),
      .sum      (walk_sum),
      .more     (walk_more)
   );

   tts_ctrl #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .nr        (nr),
      .nc        (nc),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .walk_ctl  (walk_ctl),
      .walk_start(walk_start),
      .walk_off  (walk_off),
      .walk_lim  (walk_lim),
      .walk_idx  (walk_idx),
      .walk_sum  (walk_sum),
      .walk_more (walk_more)
   );

endmodule

FILE: design/tts_check.sv
`timescale 1ns / 1ps
// Port-level checker for the screen engine and its bind to the top level.
module tts_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input tts_pkg::tts_req_type req_data,
   input logic                 rsp_valid,
   input tts_pkg::tts_rsp_type rsp_data
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe high on two cycles in a row");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   a_home_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == tts_pkg::KIND_HOME) |=> ##1
      (rsp_valid && rsp_data.cursor_row == '0 && rsp_data.cursor_col == '0))
      else $error("home transaction did not return the cursor at the origin");

endmodule

bind terminal_text_screen_engine tts_check u_tts_check (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

FILE: dv/terminal_text_screen_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the terminal text screen engine with its own screen predictor.
module terminal_text_screen_engine_tb;

   localparam int SCREEN_ROWS = tts_pkg::MAX_ROWS_DEF;
   localparam int SCREEN_COLS = tts_pkg::MAX_COLS_DEF;
   localparam int CFG_W = tts_pkg::CFG_W;
   localparam logic [2:0] ROWS_ADDR = {tts_pkg::REG_ROWS, 2'b00};
   localparam logic [2:0] COLS_ADDR = {tts_pkg::REG_COLS, 2'b00};
   localparam int PHASE_ITEMS = 140;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   tts_pkg::tts_req_type req_data;
   logic                 rsp_valid;
   tts_pkg::tts_rsp_type rsp_data;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   logic [7:0]      cells [SCREEN_ROWS*SCREEN_COLS];
   int              cur_r;
   int              cur_c;
   int              save_r;
   int              save_c;
   logic [CFG_W-1:0] rows_cfg;
   logic [CFG_W-1:0] cols_cfg;

   tts_pkg::tts_req_type command_queue[$];
   tts_pkg::tts_rsp_type cursor_results[$];
   tts_pkg::tts_rsp_type want;
   int          accepted_cnt;
   int          issued_cnt;
   int          burst_left;
   int          gap_left;
   bit          steady;
   int          errors;

   terminal_text_screen_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int clip(input int v, input int n);
      return (v < n) ? v : n - 1;
   endfunction

   function automatic int area_limit(input logic [CFG_W-1:0] cfg, input int top);
      if (cfg == '0) begin
         return 1;
      end
      return (int'(cfg) > top) ? top : int'(cfg);
   endfunction

   function automatic tts_pkg::tts_rsp_type apply_command(input tts_pkg::tts_req_type cmd);
      int nr;
      int nc;
      int pa;
      int pb;
      int base;
      int span;
      int i;
      tts_pkg::tts_rsp_type res;
      nr = area_limit(rows_cfg, SCREEN_ROWS);
      nc = area_limit(cols_cfg, SCREEN_COLS);
      pa = int'(cmd.param_a);
      pb = int'(cmd.param_b);
      res.read_char = 8'h00;
      cur_r = clip(cur_r, nr);
      cur_c = clip(cur_c, nc);
      base = cur_r * SCREEN_COLS;
      span = nc - cur_c;
      case (cmd.kind)
         tts_pkg::KIND_PRINT: begin
            cells[base + cur_c] = cmd.char_code;
            cur_c = clip(cur_c + 1, nc);
         end
         tts_pkg::KIND_CLEAR: begin
            foreach (cells[k]) cells[k] = tts_pkg::BLANK;
            cur_r = 0;
            cur_c = 0;
         end
         tts_pkg::KIND_BACK: begin
            if (cur_c != 0) cur_c--;
         end
         tts_pkg::KIND_DOWN: begin
            cur_r = clip(cur_r + 1, nr);
            cur_c = 0;
         end
         tts_pkg::KIND_FWD: begin
            cur_c = clip(cur_c + 1, nc);
         end
         tts_pkg::KIND_POS: begin
            cur_c = clip(pa, nc);
            cur_r = clip(pb, nr);
         end
         tts_pkg::KIND_UP: begin
            cur_r = (pa >= cur_r) ? 0 : cur_r - pa;
         end
         tts_pkg::KIND_DELETE: begin
            if (pa > span) pa = span;
            i = cur_c;
            while (i + pa < nc) begin
               cells[base + i] = cells[base + i + pa];
               i++;
            end
            while (i < nc) begin
               cells[base + i] = tts_pkg::BLANK;
               i++;
            end
         end
         tts_pkg::KIND_ERASE: begin
            if (pa > span) pa = span;
            for (i = 0; i < pa; i++) cells[base + cur_c + i] = tts_pkg::BLANK;
         end
         tts_pkg::KIND_HOME: begin
            cur_r = 0;
            cur_c = 0;
         end
         tts_pkg::KIND_COL: begin
            cur_c = clip(pa, nc);
         end
         tts_pkg::KIND_SAVE: begin
            save_r = cur_r;
            save_c = cur_c;
         end
         tts_pkg::KIND_RESTORE: begin
            cur_r = clip(save_r, nr);
            cur_c = clip(save_c, nc);
         end
         tts_pkg::KIND_ROW: begin
            cur_r = clip(pa, nr);
         end
         tts_pkg::KIND_READ: begin
            res.read_char = cells[clip(pb, nr) * SCREEN_COLS + clip(pa, nc)];
         end
         default: begin
         end
      endcase
      res.cursor_row = 5'(cur_r);
      res.cursor_col = 5'(cur_c);
      return res;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted_cnt == issued_cnt) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (command_queue.size() != 0) begin
            req_data <= command_queue.pop_front();
            start <= 1'b1;
            issued_cnt++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = steady ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ROWS_ADDR) rows_cfg = pwdata[CFG_W-1:0];
            else if (paddr == COLS_ADDR) cols_cfg = pwdata[CFG_W-1:0];
         end
         if (rsp_valid) begin
            if (cursor_results.size() == 0) begin
               $display("%0t: result with none expected, actual row %0d col %0d char %h",
                        $time, rsp_data.cursor_row, rsp_data.cursor_col, rsp_data.read_char);
               errors++;
            end else begin
               want = cursor_results.pop_front();
               if (rsp_data.cursor_row !== want.cursor_row ||
                   rsp_data.cursor_col !== want.cursor_col ||
                   rsp_data.read_char !== want.read_char) begin
                  $display("%0t: mismatch, expected row/col/char %0d/%0d/%h, actual %0d/%0d/%h",
                           $time, want.cursor_row, want.cursor_col, want.read_char,
                           rsp_data.cursor_row, rsp_data.cursor_col, rsp_data.read_char);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            cursor_results.push_back(apply_command(req_data));
            accepted_cnt++;
         end
      end
   end

   task automatic push_cmd(input logic [3:0] kind, input logic [7:0] ch,
                           input logic [7:0] pa, input logic [7:0] pb);
      tts_pkg::tts_req_type cmd;
      cmd.kind = kind;
      cmd.char_code = ch;
      cmd.param_a = pa;
      cmd.param_b = pb;
      command_queue.push_back(cmd);
   endtask

   function automatic logic [7:0] pick_param(input int lim);
      if ($urandom_range(0, 4) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(0, lim));
   endfunction

   task automatic push_random(input int count, input int rows, input int cols);
      int n;
      int w;
      int run;
      logic [3:0] any_kind;
      logic [7:0] ch;
      logic [7:0] pa;
      logic [7:0] pb;
      n = 0;
      while (n < count) begin
         w = $urandom_range(0, 99);
         ch = 8'($urandom_range(0, 255));
         pa = pick_param(cols + 1);
         pb = pick_param(rows + 1);
         if (w < 30) begin
            run = $urandom_range(1, 8);
            repeat (run) begin
               push_cmd(tts_pkg::KIND_PRINT, 8'($urandom_range(0, 255)), pa, pb);
               n++;
            end
         end else if (w < 45) push_cmd(tts_pkg::KIND_READ, ch, pa, pb);
         else if (w < 50) push_cmd(tts_pkg::KIND_POS, ch, pa, pb);
         else if (w < 55) push_cmd(tts_pkg::KIND_BACK, ch, pa, pb);
         else if (w < 60) push_cmd(tts_pkg::KIND_FWD, ch, pa, pb);
         else if (w < 64) push_cmd(tts_pkg::KIND_DOWN, ch, pa, pb);
         else if (w < 68) push_cmd(tts_pkg::KIND_UP, ch, pick_param(4), pb);
         else if (w < 75) push_cmd(tts_pkg::KIND_DELETE, ch, pick_param(6), pb);
         else if (w < 81) push_cmd(tts_pkg::KIND_ERASE, ch, pick_param(6), pb);
         else if (w < 84) push_cmd(tts_pkg::KIND_HOME, ch, pa, pb);
         else if (w < 87) push_cmd(tts_pkg::KIND_COL, ch, pa, pb);
         else if (w < 90) push_cmd(tts_pkg::KIND_SAVE, ch, pa, pb);
         else if (w < 93) push_cmd(tts_pkg::KIND_RESTORE, ch, pa, pb);
         else if (w < 96) push_cmd(tts_pkg::KIND_ROW, ch, pb, pa);
         else if (w < 98) push_cmd(tts_pkg::KIND_NOP, ch, pa, pb);
         else if (w < 99) begin
            if ($urandom_range(0, 3) == 0) push_cmd(tts_pkg::KIND_CLEAR, ch, pa, pb);
            else push_cmd(tts_pkg::KIND_PRINT, ch, pa, pb);
         end else begin
            any_kind = 4'($urandom_range(0, 15));
            if (any_kind == tts_pkg::KIND_CLEAR) any_kind = tts_pkg::KIND_NOP;
            push_cmd(any_kind, ch, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
         if (w >= 30) n++;
      end
   endtask

   task automatic wait_drained();
      while (command_queue.size() != 0 || start || cursor_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {26'd0, val[CFG_W-1:0]}) begin
         $display("%0t: register read mismatch at %0d, expected %h, actual %h",
                  $time, addr, {26'd0, val[CFG_W-1:0]}, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int rows_set[8];
      int cols_set[8];
      int nr;
      int nc;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (cells[k]) cells[k] = tts_pkg::BLANK;
      cur_r = 0;
      cur_c = 0;
      save_r = 0;
      save_c = 0;
      rows_cfg = tts_pkg::ROWS_RESET;
      cols_cfg = tts_pkg::COLS_RESET;
      accepted_cnt = 0;
      issued_cnt = 0;
      burst_left = 1;
      gap_left = 0;
      steady = 1'b0;
      errors = 0;
      rows_set = '{1, 32, 0, 63, 5, 32, 0, 33};
      cols_set = '{1, 32, 0, 63, 32, 3, 0, 17};
      rows_set[6] = $urandom_range(0, 63);
      cols_set[6] = $urandom_range(0, 63);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      push_cmd(tts_pkg::KIND_PRINT, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_PRINT, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(tts_pkg::KIND_READ, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_READ, 8'h00, 8'hFF, 8'hFF);
      push_cmd(tts_pkg::KIND_POS, 8'h00, 8'hFF, 8'hFF);
      push_cmd(tts_pkg::KIND_PRINT, 8'h41, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_FWD, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_READ, 8'h00, 8'd29, 8'd29);
      push_cmd(tts_pkg::KIND_DOWN, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_UP, 8'h00, 8'hFF, 8'h00);
      push_cmd(tts_pkg::KIND_UP, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_BACK, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_POS, 8'h00, 8'd5, 8'd3);
      push_cmd(tts_pkg::KIND_PRINT, 8'h31, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_PRINT, 8'h32, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_PRINT, 8'h33, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_COL, 8'h00, 8'd5, 8'h00);
      push_cmd(tts_pkg::KIND_DELETE, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_DELETE, 8'h00, 8'h01, 8'h00);
      push_cmd(tts_pkg::KIND_READ, 8'h00, 8'd5, 8'd3);
      push_cmd(tts_pkg::KIND_ERASE, 8'h00, 8'hFF, 8'h00);
      push_cmd(tts_pkg::KIND_ERASE, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_SAVE, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_ROW, 8'h00, 8'hFF, 8'h00);
      push_cmd(tts_pkg::KIND_RESTORE, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_HOME, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_NOP, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(tts_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00);
      push_cmd(tts_pkg::KIND_DELETE, 8'h00, 8'hFF, 8'h00);
      push_random(PHASE_ITEMS, 30, 30);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         csr_write(ROWS_ADDR, 32'(rows_set[p]));
         csr_write(COLS_ADDR, 32'(cols_set[p]));
         csr_check(ROWS_ADDR, 32'(rows_set[p]));
         csr_check(COLS_ADDR, 32'(cols_set[p]));
         nr = area_limit(6'(rows_set[p]), SCREEN_ROWS);
         nc = area_limit(6'(cols_set[p]), SCREEN_COLS);
         steady = (p % 3 == 1);
         push_random(PHASE_ITEMS, nr, nc);
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (errors == 0 && cursor_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
